// ===== design/sbfd_pkg.sv =====
// shared constants and beat type for the block deframer
`timescale 1ns / 1ps
`default_nettype none

package sbfd_pkg;

    // header layout and acceptance limits
    localparam int HDR_LEN             = 8;
    localparam int HDR_IDX_W           = 3;
    localparam int MAX_BLOCK_BYTES_DEF = 4096;

    localparam logic [7:0] SYNC0 = 8'h24;   // '$'
    localparam logic [7:0] SYNC1 = 8'h40;   // '@'

    localparam logic [15:0] ID_CMD_LO = 16'd128;
    localparam logic [15:0] ID_CMD_HI = 16'd767;
    localparam logic [15:0] ID_BLK_LO = 16'd4000;
    localparam logic [15:0] ID_BLK_HI = 16'd6015;

    // one output beat
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [11:0] byte_offset;
        logic [15:0] block_ident;
        logic [12:0] block_bytes;
        logic        first_mark;
        logic        last_mark;
    } beat_t;

endpackage

`default_nettype wire

// ===== design/sbfd_out_buf.sv =====
// two-entry output buffer: result register plus skid register
`timescale 1ns / 1ps
`default_nettype none

module sbfd_out_buf (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    input  wire sbfd_pkg::beat_t push_beat,
    output logic               full,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sbfd_pkg::beat_t    m_beat
);
    import sbfd_pkg::*;

    beat_t head_reg;
    beat_t skid_reg;
    logic  head_valid_reg;
    logic  skid_valid_reg;
    logic  pop;

    assign pop     = head_valid_reg && m_ready;
    assign full    = skid_valid_reg;
    assign m_valid = head_valid_reg;
    assign m_beat  = head_reg;

    // push is only offered while the skid stage is empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                head_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (push_valid) begin
                head_reg <= push_beat;
            end else begin
                head_valid_reg <= 1'b0;
            end
        end else if (push_valid) begin
            if (!head_valid_reg) begin
                head_reg       <= push_beat;
                head_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= push_beat;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/sbf_block_deframer_core.sv =====
// block deframer top level: sync hunt, header check, header release and body pass
// a body byte is pushed into the output buffer as its beat is taken and shown on the m_ side from its head
// a passing header is shown as eight beats, one a cycle while the output buffer is not
// full, once its eighth byte sets the release flag; s_ready stays low while the header
// release counter runs; otherwise one byte per cycle while the two-entry buffer is not full
// reset: synchronous, active low; returns to sync hunt and empties the output buffer
`timescale 1ns / 1ps
`default_nettype none

module sbf_block_deframer_core #(
    parameter int MAX_BLOCK_BYTES = sbfd_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic [11:0]      m_byte_offset,
    output logic [15:0]      m_block_ident,
    output logic [12:0]      m_block_bytes,
    output logic             m_first_mark,
    output logic             m_last_mark
);
    import sbfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEAD,
        PH_BODY
    } phase_t;

    phase_t               phase_reg;
    logic [7:0]           header_store_reg [HDR_LEN];
    logic [CNT_W-1:0]     byte_count_reg;
    logic [CNT_W-1:0]     held_length_reg;
    logic [15:0]          held_ident_reg;
    logic                 rel_active_reg;
    logic [HDR_IDX_W-1:0] rel_cnt_reg;

    logic             accept;
    logic             buf_full;
    logic             push_valid;
    beat_t            push_beat;
    beat_t            m_beat;
    logic [15:0]      hdr_ident;
    logic [15:0]      hdr_length;
    logic             ident_ok;
    logic             length_ok;
    logic             header_pass;
    logic             head_final;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] rel_off_inc;

    assign s_ready = !rel_active_reg && !buf_full;
    assign accept  = s_valid && s_ready;

    // header check on the arrival of its eighth byte
    assign hdr_ident  = {header_store_reg[5], header_store_reg[4]};
    assign hdr_length = {s_in_byte, header_store_reg[6]};
    assign ident_ok   = (hdr_ident >= ID_CMD_LO && hdr_ident <= ID_CMD_HI) ||
                        (hdr_ident >= ID_BLK_LO && hdr_ident <= ID_BLK_HI);
    assign length_ok  = (hdr_length >= 16'(HDR_LEN)) &&
                        (hdr_length <= 16'(MAX_BLOCK_BYTES));
    assign header_pass = (header_store_reg[1] == SYNC1) && ident_ok && length_ok;
    assign head_final  = (byte_count_reg == CNT_W'(HDR_LEN - 1));

    assign count_inc   = byte_count_reg + CNT_W'(1);
    assign rel_off_inc = CNT_W'(rel_cnt_reg) + CNT_W'(1);

    // beat selection: header release or a body byte
    always_comb begin
        push_valid            = 1'b0;
        push_beat.block_ident = held_ident_reg;
        push_beat.block_bytes = 13'(held_length_reg);
        if (rel_active_reg) begin
            push_valid            = !buf_full;
            push_beat.out_byte    = header_store_reg[rel_cnt_reg];
            push_beat.byte_offset = 12'(rel_cnt_reg);
            push_beat.first_mark  = (rel_cnt_reg == '0);
            push_beat.last_mark   = (rel_off_inc == held_length_reg);
        end else begin
            push_valid            = accept && (phase_reg == PH_BODY);
            push_beat.out_byte    = s_in_byte;
            push_beat.byte_offset = 12'(byte_count_reg);
            push_beat.first_mark  = (byte_count_reg == '0);
            push_beat.last_mark   = (count_inc == held_length_reg);
        end
    end

    // framing state, header store and release counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            byte_count_reg  <= '0;
            held_length_reg <= '0;
            held_ident_reg  <= '0;
            rel_active_reg  <= 1'b0;
            rel_cnt_reg     <= '0;
        end else begin
            if (rel_active_reg && !buf_full) begin
                rel_cnt_reg <= rel_cnt_reg + HDR_IDX_W'(1);
                if (rel_cnt_reg == HDR_IDX_W'(HDR_LEN - 1)) begin
                    rel_active_reg <= 1'b0;
                end
            end
            if (accept) begin
                unique case (phase_reg)
                    PH_HEAD: begin
                        header_store_reg[byte_count_reg[HDR_IDX_W-1:0]] <= s_in_byte;
                        byte_count_reg <= count_inc;
                        if (head_final) begin
                            phase_reg      <= PH_HUNT;
                            byte_count_reg <= '0;
                            if (header_pass) begin
                                held_ident_reg  <= hdr_ident;
                                held_length_reg <= CNT_W'(hdr_length);
                                rel_active_reg  <= 1'b1;
                                rel_cnt_reg     <= '0;
                                if (hdr_length > 16'(HDR_LEN)) begin
                                    phase_reg      <= PH_BODY;
                                    byte_count_reg <= CNT_W'(HDR_LEN);
                                end
                            end
                        end
                    end
                    PH_BODY: begin
                        byte_count_reg <= count_inc;
                        if (count_inc >= held_length_reg) begin
                            phase_reg      <= PH_HUNT;
                            byte_count_reg <= '0;
                        end
                    end
                    default: begin
                        phase_reg <= PH_HUNT;
                        if (s_in_byte == SYNC0) begin
                            header_store_reg[0] <= s_in_byte;
                            byte_count_reg      <= CNT_W'(1);
                            phase_reg           <= PH_HEAD;
                        end
                    end
                endcase
            end
        end
    end

    // output buffer
    sbfd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_beat  (push_beat),
        .full       (buf_full),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_beat     (m_beat)
    );

    assign m_out_byte    = m_beat.out_byte;
    assign m_byte_offset = m_beat.byte_offset;
    assign m_block_ident = m_beat.block_ident;
    assign m_block_bytes = m_beat.block_bytes;
    assign m_first_mark  = m_beat.first_mark;
    assign m_last_mark   = m_beat.last_mark;

`ifndef NO_ASSERTIONS
    // no input beat is taken while the header is being released
    a_release_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        rel_active_reg |-> !s_ready)
        else $error("input taken during header release");

    // header gathering always sits between the sync byte and the eighth byte
    a_head_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEAD) |->
            (byte_count_reg != '0) && (byte_count_reg < CNT_W'(HDR_LEN)))
        else $error("header byte count out of range");

    // body count never reaches the held length
    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (byte_count_reg < held_length_reg))
        else $error("body byte count past block length");

    // a first beat is the sync byte at offset zero
    a_first_is_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_first_mark) |-> (m_byte_offset == '0) && (m_out_byte == SYNC0))
        else $error("first beat is not the sync byte");
`endif

endmodule

`default_nettype wire
